>>> hdl/cdchk_pkg.sv
// Shared types, constants and helper functions for the clock drift checker.
`default_nettype none

package cdchk_pkg;

   localparam int YEAR_W  = 12;
   localparam int DAYS_W  = 20;
   localparam int TOD_W   = 17;
   localparam int SECS_W  = 36;
   localparam int THRESH_W = 16;

   typedef logic [YEAR_W-1:0]   year_type;
   typedef logic [DAYS_W-1:0]   days_type;
   typedef logic [TOD_W-1:0]    tod_type;
   typedef logic [SECS_W-1:0]   secs_type;
   typedef logic [THRESH_W-1:0] thresh_type;

   localparam int EPOCH_YEAR  = 2000;
   localparam int EPOCH_LEAPS = (EPOCH_YEAR - 1) / 4 - (EPOCH_YEAR - 1) / 100
                                + (EPOCH_YEAR - 1) / 400;

   localparam year_type   EPOCH_YEAR_V      = year_type'(EPOCH_YEAR);
   localparam year_type   LOCAL_YEAR_WRAP   = year_type'(100);
   localparam year_type   LOCAL_YEAR_BASE   = year_type'(2000);
   localparam days_type   DAYS_PER_YEAR     = days_type'(365);
   localparam days_type   EPOCH_LEAPS_V     = days_type'(EPOCH_LEAPS);
   localparam tod_type    SECS_PER_HOUR     = tod_type'(3600);
   localparam tod_type    SECS_PER_MINUTE   = tod_type'(60);
   localparam secs_type   SECS_PER_DAY      = secs_type'(86400);
   localparam thresh_type THRESHOLD_DEFAULT = thresh_type'(180);

   localparam logic [3:0] MONTH_JAN = 4'd1;
   localparam logic [3:0] MONTH_FEB = 4'd2;
   localparam logic [3:0] MONTH_DEC = 4'd12;

   typedef struct packed {
      year_type   year;
      logic [3:0] month;
      logic [4:0] day;
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
   } date_type;

   typedef struct packed {
      days_type days;
      tod_type  tod;
   } count_type;

   // Floor of a 12-bit value divided by 100, by reciprocal multiplication.
   function automatic logic [5:0] div100(input year_type n);
      logic [24:0] prod;
      prod = 25'(n) * 25'd5243;
      return prod[24:19];
   endfunction

   // Days before the first of a month in a common year; month is 1 to 12.
   function automatic logic [8:0] days_before_month(input logic [3:0] m);
      logic [8:0] d;
      case (m)
         4'd1:    d = 9'd0;
         4'd2:    d = 9'd31;
         4'd3:    d = 9'd59;
         4'd4:    d = 9'd90;
         4'd5:    d = 9'd120;
         4'd6:    d = 9'd151;
         4'd7:    d = 9'd181;
         4'd8:    d = 9'd212;
         4'd9:    d = 9'd243;
         4'd10:   d = 9'd273;
         4'd11:   d = 9'd304;
         4'd12:   d = 9'd334;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

endpackage

`default_nettype wire

>>> hdl/clock_drift_check.sv
// Top level of the clock drift checker: four-stage pipeline with valid and ready handshakes.
// Throughput: one word per cycle unless stalled; stages: input, day count, seconds, result.
// A stalled result holds the pipeline; req_ready falls only when every stage is full
// and the result word is stalled.
// Synchronous active-high reset empties all stages and sets the drift threshold to 180.
`default_nettype none

module clock_drift_check (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [11:0] req_ref_year,
   input  wire logic [3:0]  req_ref_month,
   input  wire logic [4:0]  req_ref_day,
   input  wire logic [4:0]  req_ref_hour,
   input  wire logic [5:0]  req_ref_minute,
   input  wire logic [5:0]  req_ref_second,
   input  wire logic [11:0] req_local_year,
   input  wire logic [3:0]  req_local_month,
   input  wire logic [4:0]  req_local_day,
   input  wire logic [4:0]  req_local_hour,
   input  wire logic [5:0]  req_local_minute,
   input  wire logic [5:0]  req_local_second,

   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [35:0]      rsp_ref_seconds,
   output logic [35:0]      rsp_local_seconds,
   output logic [35:0]      rsp_drift_seconds,
   output logic             rsp_update_needed,

   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data
);

   logic adv1, adv2, adv3, adv4;

   logic                  v1_ff, v2_ff, v3_ff, v4_ff;
   cdchk_pkg::date_type   ref_date_ff, local_date_ff;
   cdchk_pkg::count_type  ref_count_ff, local_count_ff;
   cdchk_pkg::secs_type   ref_secs_ff, local_secs_ff;
   cdchk_pkg::secs_type   ref_out_ff, local_out_ff, drift_out_ff;
   logic                  update_out_ff;
   cdchk_pkg::thresh_type threshold_ff;

   cdchk_pkg::date_type   ref_date_in, local_date_in;
   cdchk_pkg::count_type  ref_count_in, local_count_in;
   cdchk_pkg::secs_type   ref_secs_in, local_secs_in;
   cdchk_pkg::secs_type   drift_in;
   logic                  update_in;

   always_comb begin
      adv4      = !v4_ff || rsp_ready;
      adv3      = !v3_ff || adv4;
      adv2      = !v2_ff || adv3;
      adv1      = !v1_ff || adv2;
      req_ready = adv1;
   end

   always_comb begin
      ref_date_in.year   = req_ref_year;
      ref_date_in.month  = req_ref_month;
      ref_date_in.day    = req_ref_day;
      ref_date_in.hour   = req_ref_hour;
      ref_date_in.minute = req_ref_minute;
      ref_date_in.second = req_ref_second;

      // A two-digit local year is taken as a year of this century.
      if (req_local_year < cdchk_pkg::LOCAL_YEAR_WRAP) begin
         local_date_in.year = req_local_year + cdchk_pkg::LOCAL_YEAR_BASE;
      end else begin
         local_date_in.year = req_local_year;
      end
      local_date_in.month  = req_local_month;
      local_date_in.day    = req_local_day;
      local_date_in.hour   = req_local_hour;
      local_date_in.minute = req_local_minute;
      local_date_in.second = req_local_second;
   end

   cdchk_to_days u_ref_days (
      .date_in   (ref_date_ff),
      .count_out (ref_count_in)
   );

   cdchk_to_days u_local_days (
      .date_in   (local_date_ff),
      .count_out (local_count_in)
   );

   always_comb begin
      ref_secs_in   = cdchk_pkg::secs_type'(ref_count_ff.days) * cdchk_pkg::SECS_PER_DAY
                      + cdchk_pkg::secs_type'(ref_count_ff.tod);
      local_secs_in = cdchk_pkg::secs_type'(local_count_ff.days) * cdchk_pkg::SECS_PER_DAY
                      + cdchk_pkg::secs_type'(local_count_ff.tod);
   end

   cdchk_compare u_compare (
      .ref_secs   (ref_secs_ff),
      .local_secs (local_secs_ff),
      .threshold  (threshold_ff),
      .drift      (drift_in),
      .over       (update_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         threshold_ff <= cdchk_pkg::THRESHOLD_DEFAULT;
      end else begin
         if (adv1) begin
            v1_ff <= req_valid;
         end
         if (adv2) begin
            v2_ff <= v1_ff;
         end
         if (adv3) begin
            v3_ff <= v2_ff;
         end
         if (adv4) begin
            v4_ff <= v3_ff;
         end
         if (csr_wr_en) begin
            threshold_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         ref_date_ff   <= ref_date_in;
         local_date_ff <= local_date_in;
      end
      if (adv2) begin
         ref_count_ff   <= ref_count_in;
         local_count_ff <= local_count_in;
      end
      if (adv3) begin
         ref_secs_ff   <= ref_secs_in;
         local_secs_ff <= local_secs_in;
      end
      if (adv4) begin
         ref_out_ff    <= ref_secs_ff;
         local_out_ff  <= local_secs_ff;
         drift_out_ff  <= drift_in;
         update_out_ff <= update_in;
      end
   end

   assign rsp_valid         = v4_ff;
   assign rsp_ref_seconds   = ref_out_ff;
   assign rsp_local_seconds = local_out_ff;
   assign rsp_drift_seconds = drift_out_ff;
   assign rsp_update_needed = update_out_ff;

endmodule

`default_nettype wire

>>> hdl/cdchk_to_days.sv
// Date and time to days since the epoch (from Jan 1 of years before it) and seconds of day.
`default_nettype none

module cdchk_to_days (
   input  cdchk_pkg::date_type  date_in,
   output cdchk_pkg::count_type count_out
);

   cdchk_pkg::year_type yr;
   cdchk_pkg::year_type yr_prev;
   logic [5:0]          q_yr;
   logic [5:0]          q_prev;
   logic [5:0]          q_prev4;
   cdchk_pkg::days_type leaps_prev;
   cdchk_pkg::days_type year_days;
   logic                div4;
   logic                div100_exact;
   logic                leap;
   logic [3:0]          month_c;
   logic [4:0]          day_off;
   cdchk_pkg::days_type month_days;

   always_comb begin
      yr      = date_in.year;
      yr_prev = yr - cdchk_pkg::year_type'(1);
      q_yr    = cdchk_pkg::div100(yr);
      q_prev  = cdchk_pkg::div100(yr_prev);
      q_prev4 = cdchk_pkg::div100(cdchk_pkg::year_type'(yr_prev[11:2]));

      leaps_prev = cdchk_pkg::days_type'(yr_prev[11:2])
                   - cdchk_pkg::days_type'(q_prev)
                   + cdchk_pkg::days_type'(q_prev4);

      if (yr > cdchk_pkg::EPOCH_YEAR_V) begin
         year_days = cdchk_pkg::days_type'(yr - cdchk_pkg::EPOCH_YEAR_V)
                     * cdchk_pkg::DAYS_PER_YEAR
                     + leaps_prev - cdchk_pkg::EPOCH_LEAPS_V;
      end else begin
         year_days = '0;
      end

      // A year is a multiple of 400 when it is a multiple of 100 with a quotient divisible by 4.
      div4         = (yr[1:0] == 2'b00);
      div100_exact = (yr == cdchk_pkg::year_type'(cdchk_pkg::year_type'(q_yr)
                                                   * cdchk_pkg::year_type'(100)));
      leap         = (div4 && !div100_exact) || (div100_exact && (q_yr[1:0] == 2'b00));

      if (date_in.month < cdchk_pkg::MONTH_JAN) begin
         month_c = cdchk_pkg::MONTH_JAN;
      end else if (date_in.month > cdchk_pkg::MONTH_DEC) begin
         month_c = cdchk_pkg::MONTH_DEC;
      end else begin
         month_c = date_in.month;
      end

      month_days = cdchk_pkg::days_type'(cdchk_pkg::days_before_month(month_c));
      if ((month_c > cdchk_pkg::MONTH_FEB) && leap) begin
         month_days = month_days + cdchk_pkg::days_type'(1);
      end

      day_off = (date_in.day == 5'd0) ? 5'd0 : (date_in.day - 5'd1);

      count_out.days = year_days + month_days + cdchk_pkg::days_type'(day_off);
      count_out.tod  = cdchk_pkg::tod_type'(date_in.hour) * cdchk_pkg::SECS_PER_HOUR
                       + cdchk_pkg::tod_type'(date_in.minute) * cdchk_pkg::SECS_PER_MINUTE
                       + cdchk_pkg::tod_type'(date_in.second);
   end

endmodule

`default_nettype wire

>>> hdl/cdchk_compare.sv
// Forms the absolute difference of two second counts and checks it against the threshold.
`default_nettype none

module cdchk_compare (
   input  cdchk_pkg::secs_type   ref_secs,
   input  cdchk_pkg::secs_type   local_secs,
   input  cdchk_pkg::thresh_type threshold,
   output cdchk_pkg::secs_type   drift,
   output logic                  over
);

   always_comb begin
      if (ref_secs >= local_secs) begin
         drift = ref_secs - local_secs;
      end else begin
         drift = local_secs - ref_secs;
      end
      over = (drift > cdchk_pkg::secs_type'(threshold));
   end

endmodule

`default_nettype wire

>>> hdl/cdchk_checker.sv
// Port-level checks for the clock drift checker, bound to the top level.
`default_nettype none

module cdchk_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [35:0] rsp_ref_seconds,
   input wire logic [35:0] rsp_local_seconds,
   input wire logic [35:0] rsp_drift_seconds,
   input wire logic        rsp_update_needed
);

   a_reset_empties: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("Result word present right after reset.");

   a_drift_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_ref_seconds >= rsp_local_seconds) ?
                     (rsp_drift_seconds == rsp_ref_seconds - rsp_local_seconds) :
                     (rsp_drift_seconds == rsp_local_seconds - rsp_ref_seconds)))
      else $error("Drift is not the difference of the two second counts.");

   a_flag_bounds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_drift_seconds == 36'd0) ? !rsp_update_needed :
                     ((rsp_drift_seconds > 36'd65535) ? rsp_update_needed : 1'b1)))
      else $error("Update flag disagrees with the drift.");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ref_seconds)
                                  && $stable(rsp_local_seconds))
      else $error("Stalled result word changed.");

endmodule

bind clock_drift_check cdchk_checker u_cdchk_checker (.*);

`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for clock_drift_check: random dates, random idling, threshold sweeps.
`timescale 1ns / 100ps

module tb;

   localparam int CYCLE_LIMIT = 500000;
   localparam int LONG_HOLD   = 400;
   localparam int DRAIN_WAIT  = 8;

   typedef struct packed {
      cdchk_pkg::date_type ref_dt;
      cdchk_pkg::date_type loc_dt;
   } stamp_type;

   typedef struct packed {
      cdchk_pkg::secs_type ref_secs;
      cdchk_pkg::secs_type loc_secs;
      cdchk_pkg::secs_type drift;
      logic                late;
   } report_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [11:0] req_ref_year = '0;
   logic [3:0]  req_ref_month = '0;
   logic [4:0]  req_ref_day = '0;
   logic [4:0]  req_ref_hour = '0;
   logic [5:0]  req_ref_minute = '0;
   logic [5:0]  req_ref_second = '0;
   logic [11:0] req_local_year = '0;
   logic [3:0]  req_local_month = '0;
   logic [4:0]  req_local_day = '0;
   logic [4:0]  req_local_hour = '0;
   logic [5:0]  req_local_minute = '0;
   logic [5:0]  req_local_second = '0;

   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [35:0] rsp_ref_seconds;
   logic [35:0] rsp_local_seconds;
   logic [35:0] rsp_drift_seconds;
   logic        rsp_update_needed;

   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = '0;

   stamp_type             pending_stamps[$];
   report_type            expected_reports[$];
   stamp_type             offered_stamp;
   cdchk_pkg::thresh_type drift_limit = cdchk_pkg::THRESHOLD_DEFAULT;
   bit                    steady_sender = 1'b0;
   bit                    steady_receiver = 1'b0;
   bit                    long_hold_done = 1'b0;
   int                    gap_left = 0;
   int                    stall_left = 0;
   int                    words_checked = 0;
   int                    error_count = 0;
   int                    cycle_count = 0;

   clock_drift_check u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_ref_year      (req_ref_year),
      .req_ref_month     (req_ref_month),
      .req_ref_day       (req_ref_day),
      .req_ref_hour      (req_ref_hour),
      .req_ref_minute    (req_ref_minute),
      .req_ref_second    (req_ref_second),
      .req_local_year    (req_local_year),
      .req_local_month   (req_local_month),
      .req_local_day     (req_local_day),
      .req_local_hour    (req_local_hour),
      .req_local_minute  (req_local_minute),
      .req_local_second  (req_local_second),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_ref_seconds   (rsp_ref_seconds),
      .rsp_local_seconds (rsp_local_seconds),
      .rsp_drift_seconds (rsp_drift_seconds),
      .rsp_update_needed (rsp_update_needed),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic bit leap_year(int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   function automatic int unsigned leap_years_through(int unsigned n);
      return n / 4 - n / 100 + n / 400;
   endfunction

   function automatic int unsigned month_start(int unsigned m);
      int unsigned d;
      case (m)
         2:       d = 31;
         3:       d = 59;
         4:       d = 90;
         5:       d = 120;
         6:       d = 151;
         7:       d = 181;
         8:       d = 212;
         9:       d = 243;
         10:      d = 273;
         11:      d = 304;
         12:      d = 334;
         default: d = 0;
      endcase
      return d;
   endfunction

   function automatic cdchk_pkg::secs_type seconds_since_epoch(cdchk_pkg::date_type d);
      int unsigned       y;
      int unsigned       m;
      int unsigned       dd;
      int unsigned       epoch;
      longint unsigned   days;
      longint unsigned   total;
      y = 32'(d.year);
      m = 32'(d.month);
      dd = 32'(d.day);
      epoch = 32'(cdchk_pkg::EPOCH_YEAR);
      days = 0;
      if (y > epoch) begin
         days = 64'(365 * (y - epoch) + leap_years_through(y - 1)
                    - leap_years_through(epoch - 1));
      end
      if (m < 1) m = 1;
      if (m > 12) m = 12;
      days += 64'(month_start(m));
      if (m > 2 && leap_year(y)) days += 1;
      if (dd < 1) dd = 1;
      days += 64'(dd - 1);
      total = days * 86400 + 64'(d.hour) * 3600 + 64'(d.minute) * 60
              + 64'(d.second);
      return cdchk_pkg::secs_type'(total);
   endfunction

   function automatic report_type predict_drift(stamp_type s, cdchk_pkg::thresh_type limit);
      report_type          r;
      cdchk_pkg::date_type loc;
      loc = s.loc_dt;
      if (loc.year < cdchk_pkg::LOCAL_YEAR_WRAP) loc.year = loc.year + cdchk_pkg::LOCAL_YEAR_BASE;
      r.ref_secs = seconds_since_epoch(s.ref_dt);
      r.loc_secs = seconds_since_epoch(loc);
      r.drift = (r.ref_secs >= r.loc_secs) ? r.ref_secs - r.loc_secs
                                           : r.loc_secs - r.ref_secs;
      r.late = r.drift > cdchk_pkg::secs_type'(limit);
      return r;
   endfunction

   function automatic cdchk_pkg::date_type dt(int y, int mo, int d, int h, int mi, int s);
      cdchk_pkg::date_type r;
      r.year = 12'(y);
      r.month = 4'(mo);
      r.day = 5'(d);
      r.hour = 5'(h);
      r.minute = 6'(mi);
      r.second = 6'(s);
      return r;
   endfunction

   function automatic logic [11:0] random_year();
      int pick;
      pick = $urandom_range(0, 7);
      if (pick < 2) return 12'($urandom_range(0, 4095));
      else if (pick < 7) return 12'($urandom_range(1990, 2110));
      else return 12'($urandom_range(0, 99));
   endfunction

   function automatic cdchk_pkg::date_type random_date(bit raw);
      cdchk_pkg::date_type r;
      if (raw) begin
         r = cdchk_pkg::date_type'($urandom);
         r.year = random_year();
      end else begin
         r = dt(int'(random_year()), $urandom_range(1, 12), $urandom_range(1, 31),
                $urandom_range(0, 23), $urandom_range(0, 59), $urandom_range(0, 59));
      end
      return r;
   endfunction

   // Most pairs are well-formed; about half put the local clock near the reference.
   function automatic stamp_type random_stamp();
      stamp_type s;
      int        pick;
      int        v;
      pick = $urandom_range(0, 19);
      s.ref_dt = random_date(pick >= 17);
      if (pick < 9) begin
         s.loc_dt = s.ref_dt;
         s.loc_dt.second = 6'($urandom_range(0, 59));
         v = int'(s.ref_dt.minute) + int'($urandom_range(0, 8)) - 4;
         s.loc_dt.minute = 6'((v < 0) ? 0 : (v > 59) ? 59 : v);
         if ($urandom_range(0, 3) == 0) begin
            v = int'(s.ref_dt.hour) + int'($urandom_range(0, 40)) - 20;
            s.loc_dt.hour = 5'((v < 0) ? 0 : (v > 23) ? 23 : v);
         end
         if (s.ref_dt.year >= 2000 && s.ref_dt.year < 2100 && $urandom_range(0, 1))
            s.loc_dt.year = s.ref_dt.year - cdchk_pkg::LOCAL_YEAR_BASE;
      end else begin
         s.loc_dt = random_date(pick >= 17);
      end
      return s;
   endfunction

   task automatic push_pair(cdchk_pkg::date_type r, cdchk_pkg::date_type l);
      stamp_type s;
      s.ref_dt = r;
      s.loc_dt = l;
      pending_stamps.push_back(s);
   endtask

   task automatic wait_drained();
      while (pending_stamps.size() != 0 || req_valid || expected_reports.size() != 0)
         @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   task automatic write_threshold(cdchk_pkg::thresh_type value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      drift_limit = value;
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && req_ready)
            expected_reports.push_back(predict_drift(offered_stamp, drift_limit));
         if (req_valid && !req_ready) begin
         end else if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_stamps.size() != 0) begin
            offered_stamp = pending_stamps.pop_front();
            req_valid <= 1'b1;
            req_ref_year <= offered_stamp.ref_dt.year;
            req_ref_month <= offered_stamp.ref_dt.month;
            req_ref_day <= offered_stamp.ref_dt.day;
            req_ref_hour <= offered_stamp.ref_dt.hour;
            req_ref_minute <= offered_stamp.ref_dt.minute;
            req_ref_second <= offered_stamp.ref_dt.second;
            req_local_year <= offered_stamp.loc_dt.year;
            req_local_month <= offered_stamp.loc_dt.month;
            req_local_day <= offered_stamp.loc_dt.day;
            req_local_hour <= offered_stamp.loc_dt.hour;
            req_local_minute <= offered_stamp.loc_dt.minute;
            req_local_second <= offered_stamp.loc_dt.second;
            gap_left = steady_sender ? 0 : int'($urandom_range(0, 15));
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      report_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_reports.size() == 0) begin
               $error("result word with no expectation pending");
               error_count++;
            end else begin
               want = expected_reports.pop_front();
               if (rsp_ref_seconds !== want.ref_secs) begin
                  $error("rsp_ref_seconds: expected %0d, got %0d",
                         want.ref_secs, rsp_ref_seconds);
                  error_count++;
               end
               if (rsp_local_seconds !== want.loc_secs) begin
                  $error("rsp_local_seconds: expected %0d, got %0d",
                         want.loc_secs, rsp_local_seconds);
                  error_count++;
               end
               if (rsp_drift_seconds !== want.drift) begin
                  $error("rsp_drift_seconds: expected %0d, got %0d",
                         want.drift, rsp_drift_seconds);
                  error_count++;
               end
               if (rsp_update_needed !== want.late) begin
                  $error("rsp_update_needed: expected %0d, got %0d",
                         want.late, rsp_update_needed);
                  error_count++;
               end
            end
            words_checked++;
            stall_left = steady_receiver ? 0 : int'($urandom_range(0, 15));
            // One long back-pressure stretch so the pipeline fills and stalls the input.
            if (words_checked == 200 && !long_hold_done) begin
               stall_left = LONG_HOLD;
               long_hold_done = 1'b1;
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   initial begin
      cdchk_pkg::thresh_type limits[7];
      limits[0] = 16'd0;
      limits[1] = 16'd65535;
      limits[2] = 16'd1;
      limits[3] = 16'($urandom_range(100, 1000));
      limits[4] = cdchk_pkg::THRESHOLD_DEFAULT;
      limits[5] = 16'($urandom);
      limits[6] = 16'd180;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      push_pair(dt(2000, 1, 1, 0, 0, 0), dt(2000, 1, 1, 0, 0, 0));
      push_pair(dt(4095, 12, 31, 23, 59, 59), dt(4095, 12, 31, 23, 59, 59));
      push_pair(dt(0, 1, 1, 0, 0, 0), dt(0, 1, 1, 0, 0, 0));
      push_pair(dt(2099, 6, 15, 12, 30, 30), dt(99, 6, 15, 12, 30, 30));
      push_pair(dt(100, 2, 28, 0, 0, 0), dt(100, 3, 1, 0, 0, 0));
      push_pair(dt(1999, 12, 31, 23, 59, 59), dt(2000, 1, 1, 0, 0, 0));
      push_pair(dt(2024, 2, 29, 0, 0, 0), dt(2024, 3, 1, 0, 0, 0));
      push_pair(dt(2100, 3, 1, 0, 0, 0), dt(2000, 3, 1, 0, 0, 0));
      push_pair(dt(2400, 12, 31, 23, 59, 59), dt(1996, 3, 1, 0, 0, 0));
      push_pair(dt(2026, 0, 1, 8, 0, 0), dt(2026, 13, 1, 8, 0, 0));
      push_pair(dt(2026, 15, 0, 0, 0, 0), dt(2026, 12, 0, 0, 0, 0));
      push_pair(dt(2026, 5, 5, 31, 63, 63), dt(2026, 5, 5, 0, 0, 0));
      push_pair(dt(2026, 1, 1, 0, 3, 0), dt(26, 1, 1, 0, 0, 0));
      push_pair(dt(2026, 1, 1, 0, 3, 1), dt(2026, 1, 1, 0, 0, 0));
      push_pair(dt(2026, 1, 1, 0, 0, 0), dt(2026, 1, 1, 0, 3, 1));
      push_pair(dt(2026, 1, 1, 0, 2, 59), dt(2026, 1, 1, 0, 0, 0));
      push_pair(dt(4095, 15, 31, 31, 63, 63), dt(0, 0, 0, 0, 0, 0));
      push_pair(dt(1, 1, 1, 0, 0, 0), dt(2001, 1, 1, 0, 0, 0));
      push_pair(dt(2001, 1, 1, 0, 0, 0), dt(2000, 12, 31, 23, 59, 59));
      steady_sender = 1'b1;
      repeat (180) pending_stamps.push_back(random_stamp());
      wait_drained();
      steady_sender = 1'b0;

      for (int p = 0; p < 7; p++) begin
         write_threshold(limits[p]);
         steady_receiver = (p == 1 || p == 2);
         steady_sender = (p == 2 || p == 4);
         repeat (150) pending_stamps.push_back(random_stamp());
         wait_drained();
      end

      if (error_count == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule

>>> clock_drift_check.f
hdl/cdchk_pkg.sv
hdl/cdchk_to_days.sv
hdl/cdchk_compare.sv
hdl/clock_drift_check.sv
hdl/cdchk_checker.sv
tb/tb.sv
